/* rtl/ppu_pkg.sv */
// ----------------------------------------------------------------------------
// ppu_pkg: particle pool update shared definitions
// Request and result layouts, pool entry layout, codes and saturating adders.
// ----------------------------------------------------------------------------
`default_nettype none

package ppu_pkg;

    localparam logic OP_EMIT = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] KIND_EMIT = 2'd0;
    localparam logic [1:0] KIND_LIVE = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;

    localparam int SLOT_W = 6;

    typedef struct packed {
        logic               op;
        logic signed [31:0] life_init;
        logic signed [31:0] life_step;
        logic signed [31:0] scale_init;
        logic signed [31:0] scale_step;
        logic [47:0]        accel_xyz;
        logic [47:0]        velocity_init_xyz;
        logic [47:0]        position_init_xyz;
        logic [47:0]        color_init_rgba;
        logic [47:0]        color_step_rgba;
    } req_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic [SLOT_W-1:0]   slot;
        logic                dropped;
        logic [47:0]         position_out;
        logic signed [31:0]  size_out;
        logic [47:0]         color_out;
        logic                last;
    } rsp_t;

    typedef struct packed {
        logic [31:0] life;
        logic [31:0] life_dec;
        logic [31:0] size;
        logic [31:0] size_d;
        logic [47:0] accel;
        logic [47:0] vel;
        logic [47:0] pos;
        logic [47:0] col;
        logic [47:0] col_d;
    } entry_t;

    function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31])
            return s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
        return s[31:0];
    endfunction

    function automatic logic [31:0] sat_sub32(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {a[31], a} - {b[31], b};
        if (s[32] != s[31])
            return s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
        return s[31:0];
    endfunction

    // three Q8.8 lanes
    function automatic logic [47:0] vec_add(logic [47:0] a, logic [47:0] b);
        logic [47:0] r;
        logic [16:0] s;
        r = '0;
        for (int i = 0; i < 3; i++) begin
            s = {a[i*16+15], a[i*16 +: 16]} + {b[i*16+15], b[i*16 +: 16]};
            if (s[16] != s[15])
                r[i*16 +: 16] = s[16] ? 16'h8000 : 16'h7fff;
            else
                r[i*16 +: 16] = s[15:0];
        end
        return r;
    endfunction

    // four Q4.8 lanes
    function automatic logic [47:0] col_add(logic [47:0] a, logic [47:0] b);
        logic [47:0] r;
        logic [12:0] s;
        r = '0;
        for (int i = 0; i < 4; i++) begin
            s = {a[i*12+11], a[i*12 +: 12]} + {b[i*12+11], b[i*12 +: 12]};
            if (s[12] != s[11])
                r[i*12 +: 12] = s[12] ? 12'h800 : 12'h7ff;
            else
                r[i*12 +: 12] = s[11:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/ppu_req_if.sv */
// ----------------------------------------------------------------------------
// ppu_req_if: request channel
// Valid/ready channel carrying one particle pool request.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppu_req_if;
    logic          valid;
    logic          ready;
    ppu_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/ppu_rsp_if.sv */
// ----------------------------------------------------------------------------
// ppu_rsp_if: result channel
// Valid/ready channel carrying one particle pool result.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppu_rsp_if;
    logic          valid;
    logic          ready;
    ppu_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/particle_pool_update_core.sv */
// ----------------------------------------------------------------------------
// particle_pool_update_core: particle pool emit and tick engine
// Pool entries live in one memory; a sequencer walks the slots one at a time.
// ----------------------------------------------------------------------------
// Emit: scans one slot per cycle until a free slot or the end of the pool.
// Tick: inactive slots are skipped; an active slot is read from memory in S_TRD,
//   then updated and written back in S_TCALC, which stalls while a live result cannot be passed on.
// One request at a time; a new request is taken while the last result waits.
// Reset clears the active flags and control; pool memory is not cleared.
`default_nettype none

module particle_pool_update_core #(
    parameter int POOL_SIZE = 64
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ppu_req_if.sink    item,
    ppu_rsp_if.source  result
);

    localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CW = $clog2(POOL_SIZE + 1);
    localparam logic [CW-1:0] LAST_IDX = CW'(POOL_SIZE);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TRD,
        S_TCALC,
        S_FLUSH
    } state_t;

    state_t              state_reg;
    logic [CW-1:0]       idx_reg;
    logic [POOL_SIZE-1:0] active_reg;
    ppu_pkg::req_t       req_reg;
    ppu_pkg::rsp_t       pend_reg;
    logic                pend_valid_reg;
    ppu_pkg::rsp_t       out_reg;
    logic                out_valid_reg;

    ppu_pkg::entry_t     mem [POOL_SIZE];
    ppu_pkg::entry_t     rd_reg;

    logic [IW-1:0]       addr;
    logic                at_end;
    logic                cur_active;
    logic                out_free;
    logic                we;
    ppu_pkg::entry_t     wd;
    ppu_pkg::entry_t     upd;
    ppu_pkg::entry_t     fresh;
    logic                live;
    logic                stall;
    ppu_pkg::rsp_t       live_rsp;
    ppu_pkg::rsp_t       ack_rsp;
    ppu_pkg::rsp_t       none_rsp;

    assign addr       = idx_reg[IW-1:0];
    assign at_end     = (idx_reg == LAST_IDX);
    assign cur_active = at_end ? 1'b0 : active_reg[addr];
    assign out_free   = !out_valid_reg || result.ready;

    assign item.ready   = (state_reg == S_IDLE);
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    // per-slot update
    always_comb
    begin
        upd          = rd_reg;
        upd.life     = ppu_pkg::sat_sub32(rd_reg.life, rd_reg.life_dec);
        upd.vel      = ppu_pkg::vec_add(rd_reg.vel, rd_reg.accel);
        upd.pos      = ppu_pkg::vec_add(rd_reg.pos, upd.vel);
        upd.col      = ppu_pkg::col_add(rd_reg.col, rd_reg.col_d);
        upd.size     = ppu_pkg::sat_add32(rd_reg.size, rd_reg.size_d);
        live         = !upd.life[31] && (upd.life != '0);
        stall        = live && pend_valid_reg && !out_free;

        fresh.life     = req_reg.life_init;
        fresh.life_dec = req_reg.life_step;
        fresh.size     = req_reg.scale_init;
        fresh.size_d   = req_reg.scale_step;
        fresh.accel    = req_reg.accel_xyz;
        fresh.vel      = req_reg.velocity_init_xyz;
        fresh.pos      = req_reg.position_init_xyz;
        fresh.col      = req_reg.color_init_rgba;
        fresh.col_d    = req_reg.color_step_rgba;

        live_rsp              = '0;
        live_rsp.kind         = ppu_pkg::KIND_LIVE;
        live_rsp.slot         = ppu_pkg::SLOT_W'(addr);
        live_rsp.position_out = upd.pos;
        live_rsp.size_out     = upd.size;
        live_rsp.color_out    = upd.col;

        ack_rsp      = '0;
        ack_rsp.kind = ppu_pkg::KIND_EMIT;
        ack_rsp.slot = ppu_pkg::SLOT_W'(addr);

        none_rsp      = '0;
        none_rsp.kind = ppu_pkg::KIND_NONE;
        none_rsp.last = 1'b1;

        we = 1'b0;
        wd = upd;
        if (state_reg == S_SCAN && !at_end && !cur_active)
        begin
            we = 1'b1;
            wd = fresh;
        end
        else if (state_reg == S_TCALC && !stall)
        begin
            we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wd;
        rd_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            active_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            req_reg        <= '0;
            pend_reg       <= '0;
            out_reg        <= '0;
        end
        else
        begin
            if (out_valid_reg && result.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (item.valid)
                    begin
                        req_reg        <= item.data;
                        idx_reg        <= '0;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= (item.data.op == ppu_pkg::OP_TICK) ? S_TRD : S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (at_end)
                    begin
                        pend_reg         <= '0;
                        pend_reg.kind    <= ppu_pkg::KIND_EMIT;
                        pend_reg.dropped <= 1'b1;
                        pend_valid_reg   <= 1'b1;
                        state_reg        <= S_FLUSH;
                    end
                    else if (!cur_active)
                    begin
                        active_reg[addr] <= 1'b1;
                        pend_reg         <= ack_rsp;
                        pend_valid_reg   <= 1'b1;
                        state_reg        <= S_FLUSH;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_TRD:
                begin
                    if (at_end)
                        state_reg <= S_FLUSH;
                    else if (cur_active)
                        state_reg <= S_TCALC;
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_TCALC:
                begin
                    // hold the newest live slot back until we know if it is the final one
                    if (!stall)
                    begin
                        active_reg[addr] <= live;
                        if (live)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_reg       <= pend_reg;
                                out_valid_reg <= 1'b1;
                            end
                            pend_reg       <= live_rsp;
                            pend_valid_reg <= 1'b1;
                        end
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_TRD;
                    end
                end
                S_FLUSH:
                begin
                    if (out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_reg      <= pend_reg;
                            out_reg.last <= 1'b1;
                        end
                        else
                            out_reg <= none_rsp;
                        out_valid_reg  <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

/* sim/particle_pool_update_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// particle_pool_update_core_tb: self-checking bench for the particle pool
// Drives emit and tick requests with random gaps and random result stalls.
// A behavioral pool model predicts every result, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_pool_update_core_tb;

    localparam int SLOTS      = 64;
    localparam int IDLE_LIMIT = 6000;

    logic clk;
    logic rst_n;

    ppu_req_if req_ch ();
    ppu_rsp_if rsp_ch ();

    particle_pool_update_core #(.POOL_SIZE(SLOTS)) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (req_ch.sink),
        .result (rsp_ch.source)
    );

    // pool image
    logic        live_flag [SLOTS];
    logic [31:0] life_q    [SLOTS];
    logic [31:0] life_dec_q[SLOTS];
    logic [31:0] size_q    [SLOTS];
    logic [31:0] size_inc_q[SLOTS];
    logic [47:0] accel_q   [SLOTS];
    logic [47:0] vel_q     [SLOTS];
    logic [47:0] pos_q     [SLOTS];
    logic [47:0] col_q     [SLOTS];
    logic [47:0] col_inc_q [SLOTS];

    ppu_pkg::rsp_t pending_results[$];
    int   error_count;
    int   idle_cycles;
    int   hold_off;
    bit   no_gaps;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint clamp_signed(longint x, int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        if (x > hi) return hi;
        if (x < -hi - 1) return -hi - 1;
        return x;
    endfunction

    function automatic longint lane_value(logic [47:0] v, int sh, int w);
        longint x;
        x = longint'((v >> sh) & ((48'd1 << w) - 48'd1));
        if (x >= (longint'(1) <<< (w - 1)))
            x = x - (longint'(1) <<< w);
        return x;
    endfunction

    function automatic logic [47:0] lanes_sat_sum(logic [47:0] a, logic [47:0] b,
                                                  int w, int n);
        logic [47:0] r;
        longint      s;
        r = '0;
        for (int i = 0; i < n; i++)
        begin
            s = clamp_signed(lane_value(a, i * w, w) + lane_value(b, i * w, w), w);
            r = r | ((48'(s) & ((48'd1 << w) - 48'd1)) << (i * w));
        end
        return r;
    endfunction

    function automatic logic [31:0] word_sat(logic [31:0] a, logic [31:0] b, bit sub);
        longint x;
        x = sub ? longint'($signed(a)) - longint'($signed(b))
                : longint'($signed(a)) + longint'($signed(b));
        return 32'(clamp_signed(x, 32));
    endfunction

    function automatic int live_count();
        int c;
        c = 0;
        for (int i = 0; i < SLOTS; i++)
            if (live_flag[i]) c++;
        return c;
    endfunction

    function automatic void predict_pool(ppu_pkg::req_t r);
        ppu_pkg::rsp_t e;
        ppu_pkg::rsp_t tick_out[$];
        e = '0;
        e.last = 1'b1;
        if (r.op == ppu_pkg::OP_EMIT)
        begin
            e.kind = ppu_pkg::KIND_EMIT;
            e.dropped = 1'b1;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!live_flag[i])
                begin
                    life_q[i] = r.life_init;
                    life_dec_q[i] = r.life_step;
                    size_q[i] = r.scale_init;
                    size_inc_q[i] = r.scale_step;
                    accel_q[i] = r.accel_xyz;
                    vel_q[i] = r.velocity_init_xyz;
                    pos_q[i] = r.position_init_xyz;
                    col_q[i] = r.color_init_rgba;
                    col_inc_q[i] = r.color_step_rgba;
                    live_flag[i] = 1'b1;
                    e.slot = ppu_pkg::SLOT_W'(i);
                    e.dropped = 1'b0;
                    break;
                end
            end
            pending_results = {pending_results, e};
            return;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!live_flag[i]) continue;
            life_q[i] = word_sat(life_q[i], life_dec_q[i], 1'b1);
            if ($signed(life_q[i]) <= 0) live_flag[i] = 1'b0;
            vel_q[i] = lanes_sat_sum(vel_q[i], accel_q[i], 16, 3);
            pos_q[i] = lanes_sat_sum(pos_q[i], vel_q[i], 16, 3);
            col_q[i] = lanes_sat_sum(col_q[i], col_inc_q[i], 12, 4);
            size_q[i] = word_sat(size_q[i], size_inc_q[i], 1'b0);
            if (live_flag[i])
            begin
                e = '0;
                e.kind = ppu_pkg::KIND_LIVE;
                e.slot = ppu_pkg::SLOT_W'(i);
                e.position_out = pos_q[i];
                e.size_out = size_q[i];
                e.color_out = col_q[i];
                tick_out = {tick_out, e};
            end
        end
        if (tick_out.size() == 0)
        begin
            e = '0;
            e.kind = ppu_pkg::KIND_NONE;
            e.last = 1'b1;
            pending_results = {pending_results, e};
        end
        else
        begin
            tick_out[tick_out.size() - 1].last = 1'b1;
            pending_results = {pending_results, tick_out};
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(ppu_pkg::req_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        do @(posedge clk); while (!req_ch.ready);
        predict_pool(r);
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    function automatic ppu_pkg::req_t make_tick();
        ppu_pkg::req_t r;
        r = '0;
        r.op = ppu_pkg::OP_TICK;
        r.life_init = $urandom;
        r.accel_xyz = rand48();
        r.color_step_rgba = rand48();
        return r;
    endfunction

    function automatic ppu_pkg::req_t make_emit(bit short_life);
        ppu_pkg::req_t r;
        r.op = ppu_pkg::OP_EMIT;
        r.life_init = $urandom;
        r.life_step = $urandom;
        if (short_life)
        begin
            r.life_init = $urandom_range(1, 6) << 16;
            r.life_step = $urandom_range(1, 2) << 16;
        end
        r.scale_init = $urandom;
        r.scale_step = $urandom;
        r.accel_xyz = rand48();
        r.velocity_init_xyz = rand48();
        r.position_init_xyz = rand48();
        r.color_init_rgba = rand48();
        r.color_step_rgba = rand48();
        return r;
    endfunction

    // stop offering the last request so it is not taken twice
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic test_empty_tick();
        send_request(make_tick());
        send_request(make_tick());
    endtask

    task automatic test_extremes();
        ppu_pkg::req_t r;
        // life saturates high and never drops
        r = make_emit(1'b0);
        r.life_init = 32'h7fff_ffff;
        r.life_step = 32'h8000_0000;
        r.scale_init = 32'h7fff_fff0;
        r.scale_step = 32'h7fff_ffff;
        r.accel_xyz = {3{16'h7fff}};
        r.velocity_init_xyz = {3{16'h7fff}};
        r.position_init_xyz = {3{16'h7fff}};
        r.color_init_rgba = {4{12'h7ff}};
        r.color_step_rgba = {4{12'h7ff}};
        send_request(r);
        // dies on the first tick
        r.life_init = 32'h8000_0000;
        r.life_step = 32'h7fff_ffff;
        r.scale_init = 32'h8000_0000;
        r.scale_step = 32'h8000_0000;
        r.accel_xyz = {3{16'h8000}};
        r.velocity_init_xyz = {3{16'h8000}};
        r.position_init_xyz = {3{16'h8000}};
        r.color_init_rgba = {4{12'h800}};
        r.color_step_rgba = {4{12'h800}};
        send_request(r);
        // life reaching exactly zero
        r = make_emit(1'b0);
        r.life_init = 32'h0001_0000;
        r.life_step = 32'h0001_0000;
        send_request(r);
        r.life_init = '0;
        r.life_step = '0;
        send_request(r);
        r = make_emit(1'b0);
        r.life_init = 32'h0003_0000;
        r.life_step = 32'hffff_ffff;
        send_request(r);
        send_request(make_tick());
        send_request(make_tick());
        send_request(make_tick());
    endtask

    task automatic test_full_pool();
        ppu_pkg::req_t r;
        int   n;
        n = SLOTS - live_count();
        for (int i = 0; i < n + 2; i++)
        begin
            r = make_emit(1'b0);
            r.life_init = 32'h0002_0000;
            r.life_step = 32'h0001_0000;
            send_request(r);
        end
        send_request(make_tick());
        send_request(make_tick());
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_off = 400;
        no_gaps = 1'b1;
        for (int i = 0; i < 4; i++) send_request(make_emit(1'b1));
        send_request(make_tick());
        send_request(make_tick());
        no_gaps = 1'b0;
    endtask

    task automatic test_random();
        int pick;
        for (int i = 0; i < 70; i++)
        begin
            pick = $urandom_range(0, 99);
            no_gaps = (i / 30) % 2 == 1 && i % 30 < 10;
            if (pick < 45)
                send_request(make_emit(1'b1));
            else if (pick < 60)
                send_request(make_emit(1'b0));
            else
                send_request(make_tick());
        end
        no_gaps = 1'b0;
    endtask

    task automatic report_mismatch(string field, logic [47:0] got, logic [47:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, field, got, want);
        error_count++;
    endtask

    // result side ready with random stalls and forced hold-off
    initial
    begin
        int stall;
        stall = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                hold_off = hold_off - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                stall = pick_gap();
                rsp_ch.ready <= (stall == 0);
            end
        end
    end

    always @(posedge clk)
    begin
        ppu_pkg::rsp_t got;
        ppu_pkg::rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = rsp_ch.data;
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", 48'(got.kind), '0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.kind != want.kind)
                    report_mismatch("kind", 48'(got.kind), 48'(want.kind));
                if (got.slot != want.slot)
                    report_mismatch("slot", 48'(got.slot), 48'(want.slot));
                if (got.dropped != want.dropped)
                    report_mismatch("dropped", 48'(got.dropped), 48'(want.dropped));
                if (got.position_out != want.position_out)
                    report_mismatch("position_out", got.position_out, want.position_out);
                if (got.size_out != want.size_out)
                    report_mismatch("size_out", 48'(got.size_out), 48'(want.size_out));
                if (got.color_out != want.color_out)
                    report_mismatch("color_out", got.color_out, want.color_out);
                if (got.last != want.last)
                    report_mismatch("last", 48'(got.last), 48'(want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("particle_pool_update_core verification failed");
            $finish;
        end
    end

    initial
    begin
        error_count = 0;
        idle_cycles = 0;
        hold_off = 0;
        no_gaps = 1'b0;
        for (int i = 0; i < SLOTS; i++) live_flag[i] = 1'b0;
        rst_n = 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_tick();
        test_extremes();
        test_full_pool();
        test_backpressure();
        test_random();

        wait_drained();
        repeat (300) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("particle_pool_update_core verification clean");
        else
            $display("particle_pool_update_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire
